/* design/assert_macros.svh */
// Assertion macros for the checker file of the feedback delay.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define RPFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is checked during reset as well.
`define RPFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rpfd_pkg.sv */
// Shared constants, types and the rhythm pattern table of the feedback delay.
// No dependencies.
`default_nettype none

package rpfd_pkg;

   localparam int MAX_DELAY_DEFAULT = 65536;
   localparam int CHANNELS_DEFAULT  = 2;

   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 3;
   localparam int COUNT_W    = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX      = 2'd3;

   // register reset values
   localparam logic [15:0] DELAY_RESET    = 16'd24000;
   localparam logic [2:0]  PATTERN_RESET  = 3'd0;
   localparam logic [14:0] FEEDBACK_RESET = 15'd11469;
   localparam logic [15:0] MIX_RESET      = 16'd16384;

   // Q15 constants
   localparam logic [16:0] Q15_ONE      = 17'd32768;
   localparam logic [14:0] TAP_LOW_GAIN = 15'd9830;
   localparam logic [14:0] FEEDBACK_MAX = 15'd22938;
   localparam logic [15:0] MIX_MAX      = 16'd32768;

   function automatic logic [7:0] rhythm_pattern(input logic [STEP_W-1:0] sel);
      logic [7:0] bits;
      unique case (sel)
         3'd0: bits = 8'hAA;
         3'd1: bits = 8'hCC;
         3'd2: bits = 8'hF0;
         3'd3: bits = 8'hDB;
         3'd4: bits = 8'h96;
         3'd5: bits = 8'hE4;
         3'd6: bits = 8'hBA;
         3'd7: bits = 8'hFF;
         default: bits = 8'hFF;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

/* design/rpfd_delay_mod.sv */
// Delay length modulo MAX_DELAY, by reciprocal multiply and one correction.
// Recomputes after reset and after every delay write; depends on rpfd_pkg.
`default_nettype none

module rpfd_delay_mod #(
   parameter int MAX_DELAY = rpfd_pkg::MAX_DELAY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic [15:0] delay,
   output logic      [15:0] delay_mod,
   output logic             ready
);

   localparam logic [39:0] RECIP = 40'((64'd1 << 32) / MAX_DELAY);

   logic [39:0] prod_ff;
   logic [15:0] delay_d1_ff;
   logic [15:0] rem_ff;
   logic [15:0] dmod_ff;
   logic [1:0]  settle_ff, settle_in;

   // quotient estimate never exceeds the true one, so one subtract corrects it
   always_ff @(posedge clock) begin
      prod_ff     <= 40'(delay) * RECIP;
      delay_d1_ff <= delay;
      rem_ff      <= 16'(28'(delay_d1_ff) - 28'(prod_ff[39:32]) * 28'(MAX_DELAY));
      if (20'(rem_ff) >= 20'(MAX_DELAY)) begin
         dmod_ff <= 16'(20'(rem_ff) - 20'(MAX_DELAY));
      end else begin
         dmod_ff <= rem_ff;
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (restart) begin
         settle_in = 2'd0;
      end else if (settle_ff != 2'd3) begin
         settle_in = settle_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign delay_mod = dmod_ff;
   assign ready     = (settle_ff == 2'd3);

endmodule

`default_nettype wire

/* design/rpfd_store.sv */
// Delay sample store: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module rpfd_store #(
   parameter int DEPTH = 131072,
   parameter int AW    = 17,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:DEPTH-1];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/rhythmic_pattern_feedback_delay.sv */
// Two-channel feedback delay with a rhythm-gated tap, Q1.15 samples.
// States: a taken request passes READ, SCALE and MIX; WRITE registers the result
// once any earlier result is accepted. Requests are taken only in IDLE, after the
// read-scale-multiply-write sequence around the single-port-pair delay store.
// Reset: synchronous; requests are held off after reset and after each delay
// write while the delay modulo settles. The store needs no clearing pass.
`default_nettype none

module rhythmic_pattern_feedback_delay #(
   parameter int MAX_DELAY = rpfd_pkg::MAX_DELAY_DEFAULT,
   parameter int CHANNELS  = rpfd_pkg::CHANNELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample_in
   input  wire logic        req_tuser,   // [0] channel
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] sample_out
   // configuration
   input  wire logic                           csr_wren,
   input  wire logic [rpfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpfd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH_USED = (CHANNELS > 2) ? 2 : CHANNELS;
   localparam int IDXW    = $clog2(MAX_DELAY);
   localparam int SUMW    = IDXW + 1;
   localparam int AW      = $clog2(CH_USED * MAX_DELAY);
   localparam int CW      = rpfd_pkg::COUNT_W;
   localparam int SW      = rpfd_pkg::STEP_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_MIX   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   function automatic rpfd_pkg::sample_type sat16(input logic signed [19:0] v);
      rpfd_pkg::sample_type r;
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [15:0] delay_ff;
   logic [2:0]  pattern_ff;
   logic [14:0] feedback_ff;
   logic [15:0] mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= rpfd_pkg::DELAY_RESET;
         pattern_ff  <= rpfd_pkg::PATTERN_RESET;
         feedback_ff <= rpfd_pkg::FEEDBACK_RESET;
         mix_ff      <= rpfd_pkg::MIX_RESET;
      end else if (csr_wren) begin
         unique case (csr_index)
            rpfd_pkg::CSR_DELAY:    delay_ff    <= csr_wdata;
            rpfd_pkg::CSR_PATTERN:  pattern_ff  <= csr_wdata[2:0];
            rpfd_pkg::CSR_FEEDBACK: feedback_ff <= csr_wdata[14:0];
            rpfd_pkg::CSR_MIX:      mix_ff      <= csr_wdata;
            default:                delay_ff    <= delay_ff;
         endcase
      end
   end

   logic [14:0] fb_gain;
   logic [15:0] wet_gain;
   logic [16:0] dry_gain;
   assign fb_gain  = (feedback_ff > rpfd_pkg::FEEDBACK_MAX) ? rpfd_pkg::FEEDBACK_MAX
                                                            : feedback_ff;
   assign wet_gain = (mix_ff > rpfd_pkg::MIX_MAX) ? rpfd_pkg::MIX_MAX : mix_ff;
   assign dry_gain = rpfd_pkg::Q15_ONE - 17'(wet_gain);

   // delay length modulo the per-channel store depth
   logic [15:0] delay_mod;
   logic        dmod_ready;

   rpfd_delay_mod #(
      .MAX_DELAY(MAX_DELAY)
   ) u_delay_mod (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wren && (csr_index == rpfd_pkg::CSR_DELAY)),
      .delay    (delay_ff),
      .delay_mod(delay_mod),
      .ready    (dmod_ready)
   );

   // per-channel context; wrap marks a store whose every entry has been written
   logic [IDXW-1:0] wp_ff   [0:CH_USED-1];
   logic [CW-1:0]   sis_ff  [0:CH_USED-1];
   logic [SW-1:0]   step_ff [0:CH_USED-1];
   logic            wrap_ff [0:CH_USED-1];

   logic [2:0] state_ff, state_in;

   logic                 ch_ff;
   logic                 absent_ff;
   rpfd_pkg::sample_type x_ff;
   logic [SUMW-1:0]      rdsum_ff;
   logic [IDXW-1:0]      wp_cur_ff;
   logic                 wrap_cur_ff;
   logic [CW-1:0]        sis_cur_ff;
   logic [SW-1:0]        step_cur_ff;
   logic                 tap_ff;
   logic                 hit_ff;
   rpfd_pkg::sample_type delayed_ff;
   logic signed [31:0]   pfb_ff;
   logic signed [33:0]   pdry_ff;
   logic signed [33:0]   pwet_ff;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   rpfd_pkg::sample_type rsp_data_ff;

   logic req_take;
   logic write_go;
   assign req_tready = (state_ff == ST_IDLE) && dmod_ready;
   assign req_take   = req_tvalid && req_tready;
   assign write_go   = (state_ff == ST_WRITE) && (!rsp_tvalid_ff || rsp_tready);

   // request-side context lookup
   logic            sel_ch;
   logic [IDXW-1:0] wp_sel;
   logic [7:0]      pat_bits;
   assign sel_ch   = (CH_USED > 1) ? req_tuser : 1'b0;
   assign wp_sel   = wp_ff[sel_ch];
   assign pat_bits = rpfd_pkg::rhythm_pattern(pattern_ff);

   // read index and fill check
   logic [IDXW-1:0] rd_idx;
   assign rd_idx = (rdsum_ff >= SUMW'(MAX_DELAY)) ? IDXW'(rdsum_ff - SUMW'(MAX_DELAY))
                                                  : IDXW'(rdsum_ff);

   logic          base_sel;
   logic [AW-1:0] base_addr;
   assign base_sel  = ch_ff && !absent_ff;
   assign base_addr = base_sel ? AW'(MAX_DELAY) : AW'(0);

   // delay store
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [15:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [15:0]   mem_rd_data;

   rpfd_store #(
      .DEPTH(CH_USED * MAX_DELAY),
      .AW   (AW),
      .DW   (rpfd_pkg::SAMPLE_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign mem_rd_en   = (state_ff == ST_READ);
   assign mem_rd_addr = base_addr + AW'(rd_idx);

   // tap scaling
   rpfd_pkg::sample_type stored;
   logic signed [31:0]   scale_prod;
   logic signed [31:0]   scale_rnd;
   assign stored     = hit_ff ? mem_rd_data : 16'sd0;
   assign scale_prod = 32'(stored) * signed'({17'd0, rpfd_pkg::TAP_LOW_GAIN});
   assign scale_rnd  = (scale_prod + 32'sd16384) >>> 15;

   // write-back and mix rounding
   logic signed [31:0]   fb_rnd;
   logic signed [33:0]   mix_rnd;
   rpfd_pkg::sample_type back_sat;
   rpfd_pkg::sample_type out_sat;
   assign fb_rnd   = (pfb_ff + 32'sd16384) >>> 15;
   assign mix_rnd  = (pdry_ff + pwet_ff + 34'sd16384) >>> 15;
   assign back_sat = sat16(20'(x_ff) + fb_rnd[19:0]);
   assign out_sat  = sat16(mix_rnd[19:0]);

   assign mem_wr_en   = write_go && !absent_ff;
   assign mem_wr_addr = base_addr + AW'(wp_cur_ff);
   assign mem_wr_data = back_sat;

   // context advance
   logic [SUMW-1:0] wp_inc;
   logic [IDXW-1:0] wp_next;
   logic            wrap_now;
   logic [CW-1:0]   sis_inc;
   logic [CW-1:0]   step_size;
   logic            step_adv;
   assign wp_inc    = SUMW'(wp_cur_ff) + SUMW'(1);
   assign wrap_now  = (wp_inc == SUMW'(MAX_DELAY));
   assign wp_next   = wrap_now ? IDXW'(0) : IDXW'(wp_inc);
   assign sis_inc   = sis_cur_ff + CW'(1);
   assign step_size = (delay_ff[15:3] == 13'd0) ? CW'(1) : CW'(delay_ff[15:3]);
   assign step_adv  = (sis_inc >= step_size);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_READ;
         ST_READ:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MIX;
         ST_MIX:   state_in = ST_WRITE;
         ST_WRITE: if (write_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (write_go) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CH_USED; i++) begin
            wp_ff[i]   <= '0;
            sis_ff[i]  <= '0;
            step_ff[i] <= '0;
            wrap_ff[i] <= 1'b0;
         end
      end else if (write_go && !absent_ff) begin
         wp_ff[base_sel]   <= wp_next;
         wrap_ff[base_sel] <= wrap_cur_ff || wrap_now;
         sis_ff[base_sel]  <= step_adv ? CW'(0) : sis_inc;
         step_ff[base_sel] <= step_adv ? step_cur_ff + SW'(1) : step_cur_ff;
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff       <= req_tuser;
         absent_ff   <= req_tuser && (CHANNELS < 2);
         x_ff        <= req_tdata;
         wp_cur_ff   <= wp_sel;
         wrap_cur_ff <= wrap_ff[sel_ch];
         sis_cur_ff  <= sis_ff[sel_ch];
         step_cur_ff <= step_ff[sel_ch];
         tap_ff      <= pat_bits[step_ff[sel_ch]];
         rdsum_ff    <= SUMW'(wp_sel) + SUMW'(MAX_DELAY) - SUMW'(delay_mod);
      end
      if (state_ff == ST_READ) begin
         // entries not yet written since reset read as zero
         hit_ff <= wrap_cur_ff || (rd_idx < wp_cur_ff);
      end
      if (state_ff == ST_SCALE) begin
         delayed_ff <= tap_ff ? stored : scale_rnd[15:0];
      end
      if (state_ff == ST_MIX) begin
         pfb_ff  <= 32'(delayed_ff) * signed'({17'd0, fb_gain});
         pdry_ff <= 34'(x_ff) * signed'({17'd0, dry_gain});
         pwet_ff <= 34'(delayed_ff) * signed'({18'd0, wet_gain});
      end
      if (write_go) begin
         rsp_data_ff <= absent_ff ? x_ff : out_sat;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/rpfd_checker.sv */
// Port-level checks of the feedback delay, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpfd_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   `RPFD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready, "outputs not quiet after reset")
   `RPFD_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `RPFD_ASSERT(a_result_follows, clock, reset, req_tvalid && req_tready |-> ##5 rsp_tvalid, "no result after request")
   `RPFD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind rhythmic_pattern_feedback_delay rpfd_port_checks u_rpfd_checker (.*);

`default_nettype wire
